>>> hdl/tp16_pkg.sv
// shared types, constants and codes of the tiny 16-bit processor core
`timescale 1ns / 1ps

package tp16_pkg;

  // data memory size in bytes, a power of two
  localparam int DATA_BYTES = 512;
  localparam int REG_COUNT  = 16;

  localparam int ADDR_W     = $clog2(DATA_BYTES);
  localparam int BANK_DEPTH = DATA_BYTES / 2;
  localparam int BANK_W     = ADDR_W - 1;
  localparam int REG_W      = $clog2(REG_COUNT);
  localparam int PC_W       = 9;
  localparam int WORD_W     = 16;

  // command queue between front and back
  localparam int CQ_DEPTH = 4;
  localparam int CQ_W     = $clog2(CQ_DEPTH);

  // result queue
  localparam int RQ_DEPTH = 2;
  localparam int RQ_W     = $clog2(RQ_DEPTH);

  localparam logic [WORD_W-1:0] ADDR_BIAS = WORD_W'(512);
  localparam logic [PC_W-1:0]   PC_STEP   = PC_W'(2);

  // item operations
  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_WREG = 2'd1;
  localparam logic [1:0] OP_WMEM = 2'd2;
  localparam logic [1:0] OP_RMEM = 2'd3;

  // instruction opcodes
  localparam logic [3:0] OPC_ADD   = 4'd0;
  localparam logic [3:0] OPC_ADDI  = 4'd1;
  localparam logic [3:0] OPC_SUB   = 4'd2;
  localparam logic [3:0] OPC_SUBI  = 4'd3;
  localparam logic [3:0] OPC_MUL   = 4'd6;
  localparam logic [3:0] OPC_MULI  = 4'd7;
  localparam logic [3:0] OPC_LOAD  = 4'd8;
  localparam logic [3:0] OPC_STORE = 4'd10;
  localparam logic [3:0] OPC_JUMP  = 4'd12;
  localparam logic [3:0] OPC_BEQZ  = 4'd13;
  localparam logic [3:0] OPC_HALT  = 4'd14;

  typedef enum logic [3:0] {
    K_NOP,
    K_ADD,
    K_SUB,
    K_MUL,
    K_LOAD,
    K_STORE,
    K_JUMP,
    K_BRANCH,
    K_HALT,
    K_WREG,
    K_WMEM,
    K_RMEM
  } kind_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_READ,
    B_EXEC,
    B_LOAD
  } back_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [3:0]        opcode;
    logic [3:0]        field_a;
    logic [3:0]        field_b;
    logic [3:0]        field_c;
    logic [3:0]        reg_index;
    logic [8:0]        mem_address;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [8:0]         next_pc;
    logic               halted;
    logic signed [15:0] read_value;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    kind_t               kind;
    logic                is_exec;
    logic                use_imm;
    logic [REG_W-1:0]    ra;
    logic [REG_W-1:0]    rb;
    logic [REG_W-1:0]    rc;
    logic [WORD_W-1:0]   imm;
    logic [PC_W-1:0]     off;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   value;
  } cmd_t;

  // back to front control
  typedef struct packed {
    logic clearing;
    logic take;
  } back_status_t;

endpackage

>>> hdl/tp16_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tp16_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/tp16_front.sv
// front end: accepts items, classifies them and queues commands for the back end
`timescale 1ns / 1ps

module tp16_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  tp16_pkg::in_item_t      instr,
  input  tp16_pkg::back_status_t  status,
  output logic                    cmd_valid,
  output tp16_pkg::cmd_t          cmd
);
  import tp16_pkg::*;

  cmd_t            q [CQ_DEPTH];
  logic [CQ_W-1:0] wr_ptr;
  logic [CQ_W-1:0] rd_ptr;
  logic [CQ_W:0]   count;
  logic            accept;
  cmd_t            dec;

  // classify one item
  always_comb begin
    dec         = '0;
    dec.kind    = K_NOP;
    dec.ra      = instr.field_a;
    dec.rb      = instr.field_b;
    dec.rc      = instr.field_c;
    dec.imm     = {{(WORD_W-4){instr.field_c[3]}}, instr.field_c};
    dec.off     = {instr.field_b[3], instr.field_b, instr.field_c};
    dec.addr    = ADDR_W'(instr.mem_address);
    dec.value   = instr.value;
    dec.is_exec = 1'b0;
    dec.use_imm = 1'b0;
    unique case (instr.operation)
      OP_EXEC: begin
        dec.is_exec = 1'b1;
        unique case (instr.opcode)
          OPC_ADD:   dec.kind = K_ADD;
          OPC_ADDI:  begin dec.kind = K_ADD; dec.use_imm = 1'b1; end
          OPC_SUB:   dec.kind = K_SUB;
          OPC_SUBI:  begin dec.kind = K_SUB; dec.use_imm = 1'b1; end
          OPC_MUL:   dec.kind = K_MUL;
          OPC_MULI:  begin dec.kind = K_MUL; dec.use_imm = 1'b1; end
          OPC_LOAD:  dec.kind = K_LOAD;
          OPC_STORE: dec.kind = K_STORE;
          OPC_JUMP:  dec.kind = K_JUMP;
          OPC_BEQZ:  dec.kind = K_BRANCH;
          OPC_HALT:  dec.kind = K_HALT;
          default:   dec.kind = K_NOP;
        endcase
      end
      OP_WREG: begin
        dec.kind = K_WREG;
        dec.ra   = instr.reg_index;
      end
      OP_WMEM: dec.kind = K_WMEM;
      OP_RMEM: dec.kind = K_RMEM;
    endcase
  end

  assign full      = (count == (CQ_W+1)'(CQ_DEPTH)) || status.clearing;
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (status.take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({accept, status.take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (CQ_W+1)'(CQ_DEPTH))
    else $error("command queue overfilled");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    status.take |-> cmd_valid)
    else $error("back end took from an empty command queue");

endmodule

>>> hdl/tp16_result_queue.sv
// two-entry result queue in front of the result ports
`timescale 1ns / 1ps

module tp16_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tp16_pkg::out_item_t item,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output tp16_pkg::out_item_t result
);
  import tp16_pkg::*;

  out_item_t       q [RQ_DEPTH];
  logic [RQ_W-1:0] wr_ptr;
  logic [RQ_W-1:0] rd_ptr;
  logic [RQ_W:0]   count;
  logic            do_pop;

  assign full   = (count == (RQ_W+1)'(RQ_DEPTH));
  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign result = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/tp16_back.sv
// back end: register file, data memory, program counter and the execute sequencer
`timescale 1ns / 1ps

module tp16_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  tp16_pkg::cmd_t          cmd,
  output tp16_pkg::back_status_t  status,
  output logic                    res_push,
  output tp16_pkg::out_item_t     res_item,
  input  logic                    res_full
);
  import tp16_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [BANK_W-1:0] clr_cnt;
  cmd_t              cur;
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  logic              halt;
  logic              halt_next;
  logic              odd;
  logic              odd_next;

  logic [WORD_W-1:0] ra_q, rb_q, rc_q;
  logic              rf_we;
  logic [REG_W-1:0]  rf_waddr;
  logic [WORD_W-1:0] rf_wdata;

  logic              dm_we;
  logic [BANK_W-1:0] even_addr, odd_addr;
  logic [7:0]        even_wdata, odd_wdata;
  logic [7:0]        even_q, odd_q;

  logic                active;
  logic [WORD_W-1:0]   opnd;
  logic [WORD_W-1:0]   prod;
  logic [WORD_W-1:0]   alu;
  logic [WORD_W-1:0]   sum_ld, sum_st;
  logic [ADDR_W-1:0]   mem_a;
  logic [BANK_W-1:0]   row;
  logic [WORD_W-1:0]   wword;
  logic [WORD_W-1:0]   rword;

  // register file: one copy per read port, all written together
  tp16_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(cmd.ra), .rdata(ra_q)
  );
  tp16_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(cmd.rb), .rdata(rb_q)
  );
  tp16_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_c (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(cmd.rc), .rdata(rc_q)
  );

  // data memory split into even and odd byte banks
  tp16_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_dm_even (
    .clk(clk), .we(dm_we), .waddr(even_addr), .wdata(even_wdata),
    .raddr(even_addr), .rdata(even_q)
  );
  tp16_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_dm_odd (
    .clk(clk), .we(dm_we), .waddr(odd_addr), .wdata(odd_wdata),
    .raddr(odd_addr), .rdata(odd_q)
  );

  // datapath of the execute cycle
  always_comb begin
    active = !(cur.is_exec && halt);
    opnd   = cur.use_imm ? cur.imm : rc_q;
    // only the low word of the product is kept
    prod   = rb_q * opnd;
    unique case (cur.kind)
      K_ADD:   alu = rb_q + opnd;
      K_SUB:   alu = rb_q - opnd;
      K_MUL:   alu = prod;
      default: alu = cur.value;
    endcase
    sum_ld = rb_q + rc_q - ADDR_BIAS;
    sum_st = ra_q + rb_q - ADDR_BIAS;
    unique case (cur.kind)
      K_LOAD:  mem_a = sum_ld[ADDR_W-1:0];
      K_STORE: mem_a = sum_st[ADDR_W-1:0];
      default: mem_a = cur.addr;
    endcase
    row   = mem_a[ADDR_W-1:1];
    wword = (cur.kind == K_STORE) ? rc_q : cur.value;
    rword = odd ? {odd_q, even_q} : {even_q, odd_q};
  end

  // sequencer
  always_comb begin
    state_next  = state;
    pc_next     = pc;
    halt_next   = halt;
    odd_next    = odd;
    status      = '0;
    res_push    = 1'b0;
    res_item    = '0;
    rf_we       = 1'b0;
    rf_waddr    = cur.ra;
    rf_wdata    = alu;
    dm_we       = 1'b0;
    even_addr   = mem_a[0] ? row + 1'b1 : row;
    odd_addr    = row;
    even_wdata  = mem_a[0] ? wword[7:0] : wword[15:8];
    odd_wdata   = mem_a[0] ? wword[15:8] : wword[7:0];
    unique case (state)
      B_CLEAR: begin
        status.clearing = 1'b1;
        rf_we      = 1'b1;
        rf_waddr   = clr_cnt[REG_W-1:0];
        rf_wdata   = '0;
        dm_we      = 1'b1;
        even_addr  = clr_cnt;
        odd_addr   = clr_cnt;
        even_wdata = '0;
        odd_wdata  = '0;
        if (clr_cnt == '1) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        // register reads issue from the queue head as it is taken
        if (cmd_valid && !res_full) begin
          status.take = 1'b1;
          state_next  = B_EXEC;
        end
      end
      B_EXEC: begin
        if (cur.is_exec && active) begin
          pc_next = pc + PC_STEP;
          if (cur.kind == K_JUMP || (cur.kind == K_BRANCH && ra_q == '0)) begin
            pc_next = pc + cur.off;
          end
          if (cur.kind == K_HALT) begin
            halt_next = 1'b1;
          end
        end
        if (active && (cur.kind == K_ADD || cur.kind == K_SUB || cur.kind == K_MUL
                       || cur.kind == K_WREG)) begin
          rf_we = 1'b1;
        end
        if (active && (cur.kind == K_STORE || cur.kind == K_WMEM)) begin
          dm_we = 1'b1;
        end
        if (active && (cur.kind == K_LOAD || cur.kind == K_RMEM)) begin
          odd_next   = mem_a[0];
          state_next = B_LOAD;
        end else begin
          res_push            = 1'b1;
          res_item.next_pc    = pc_next;
          res_item.halted     = halt_next;
          res_item.read_value = '0;
          state_next          = B_READ;
        end
      end
      B_LOAD: begin
        if (cur.kind == K_LOAD) begin
          rf_we    = 1'b1;
          rf_wdata = rword;
        end
        res_push            = 1'b1;
        res_item.next_pc    = pc;
        res_item.halted     = halt;
        res_item.read_value = (cur.kind == K_RMEM) ? rword : '0;
        state_next          = B_READ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pc      <= '0;
      halt    <= 1'b0;
    end else begin
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      pc   <= pc_next;
      halt <= halt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (status.take) begin
      cur <= cmd;
    end
    odd <= odd_next;
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt |=> halt)
    else $error("halt flag dropped");

  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    status.take |=> (state == B_EXEC) && $stable(pc))
    else $error("taken command did not enter execute");

  a_load_pc: assert property (@(posedge clk) disable iff (rst)
    (state == B_LOAD) |=> $stable(pc) && $stable(halt))
    else $error("program state changed during load return");

endmodule

>>> hdl/tiny_16bit_processor_core.sv
// top level of the tiny 16-bit processor core
`timescale 1ns / 1ps

// A small 16-bit core with sixteen registers, a 512-byte big-endian data
// memory, a 9-bit byte program counter and a halt flag. Each item is one of:
// execute a fetched instruction, write a register, write a data word, or read
// a data word; every item gives exactly one result with the program counter
// and halt flag after the item, plus the read word for a data read (else 0).
// Items enter a four-entry command queue through push/full and results leave
// a two-entry result queue through empty/pop, so either side may stall freely.
// The back end handles one item at a time: a registered register-file read, then
// execute, and for load and data-read items a further load state that waits for
// the registered read of the data memory banks. After reset a clearing pass
// zeroes the data memory and registers, during which full stays high.
module tiny_16bit_processor_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tp16_pkg::in_item_t  instr,
  input  logic                pop,
  output logic                empty,
  output tp16_pkg::out_item_t result
);
  import tp16_pkg::*;

  // front to back command path
  cmd_t         cmd;
  logic         cmd_valid;
  back_status_t status;

  // back to result queue
  logic         res_push;
  out_item_t    res_item;
  logic         res_full;

  // decode and command queue
  tp16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .instr     (instr),
    .status    (status),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // execute sequencer with register file and data memory
  tp16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .status    (status),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  // results wait here until popped
  tp16_result_queue u_result_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .item   (res_item),
    .full   (res_full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule
